>>> sv/stack_calculator_top_assert.svh
// Assertion macros for the stack calculator.
`ifndef STACK_CALCULATOR_TOP_ASSERT_SVH
`define STACK_CALCULATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack calculator assertion failed");
`define SC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack calculator assertion failed");
`else
`define SC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/sc_pkg.sv
// Shared constants, opcodes, status codes and control structs of the stack calculator.
package sc_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_W = 32;
  localparam int OP_W = 3;
  localparam int POS_W = 6;
  localparam int ST_W = 3;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_POP = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV = 3'd5;
  localparam logic [OP_W-1:0] OP_RD_TOP = 3'd6;
  localparam logic [OP_W-1:0] OP_RD_BOT = 3'd7;

  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [ST_W-1:0] ST_FEW = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd3;
  localparam logic [ST_W-1:0] ST_DIVZERO = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL = 3'd5;

  typedef struct packed {
    logic load;
    logic rd_next;
    logic cap_b;
    logic cap_a;
    logic exec;
    logic div_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic err_early;
    logic is_push;
    logic is_binary;
    logic is_div;
    logic b_zero;
    logic div_done;
  } stat_t;

endpackage

>>> sv/stack_calculator_top.sv
// Stack calculator: bounded stack of 32-bit words with add, sub, mul and floor divide.
//
// Input channel (in_valid/in_ready) carries operation, push_value and position;
// output channel (out_valid/out_ready) returns value, status and depth_used,
// exactly one result per input transfer, in order.
// Divide runs on the bit-serial divider: start, one step per quotient bit, sign
// fix-up and handoff. The stack is a single-port-read memory, so binary
// operations fetch their two operands on successive cycles.
// One item is in flight at a time; in_ready is high only while idle, so a new
// item is not taken until the last one has been committed.
// The result sits in an output register: a new item can be taken while the
// last result is still waiting; a stalled receiver holds the finished
// next result in the controller until the register frees.
// Reset (rst, synchronous) empties the stack and clears both channels;
// stack memory contents are not cleared and need no clearing pass.
module stack_calculator_top #(
  parameter int STACK_DEPTH = sc_pkg::STACK_DEPTH_DEF,
  parameter int CNT_W = $clog2(STACK_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [sc_pkg::OP_W-1:0]  operation,
  input  logic signed [31:0]       push_value,
  input  logic [sc_pkg::POS_W-1:0] position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       value,
  output logic [sc_pkg::ST_W-1:0]  status,
  output logic [CNT_W-1:0]         depth_used
);

  `include "stack_calculator_top_assert.svh"

  sc_pkg::cmd_t  cmd;
  sc_pkg::stat_t stat;

  sc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sc_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (operation),
    .push_value (push_value),
    .position   (position),
    .value      (value),
    .status     (status),
    .depth_used (depth_used)
  );

  `SC_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `SC_ASSERT_IMP(a_err_value_zero, clk, rst, out_valid && status != sc_pkg::ST_OK, value == 32'sd0)
  `SC_ASSERT_IMP(a_depth_bound, clk, rst, out_valid, depth_used <= CNT_W'(STACK_DEPTH))
  `SC_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.commit, !out_valid || out_ready)

endmodule

>>> sv/sc_div.sv
// Iterative signed floor divider, one quotient bit per cycle.
module sc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic        fix;
  logic [4:0]  cnt;
  logic        neg;
  logic [31:0] q;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic [31:0] rem_next;
  logic        ge;

  always_comb begin
    rem_sh = {rem, q[31]};
    diff = rem_sh - {1'b0, dvs};
    ge = !diff[32];
    rem_next = ge ? diff[31:0] : rem_sh[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'd31;
        neg <= dividend[31] ^ divisor[31];
        q <= dividend[31] ? (~dividend + 32'd1) : dividend;
        dvs <= divisor[31] ? (~divisor + 32'd1) : divisor;
        rem <= 32'd0;
      end else if (busy) begin
        rem <= rem_next;
        q <= {q[30:0], ge};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          fix <= 1'b1;
        end
      end else if (fix) begin
        fix <= 1'b0;
        done <= 1'b1;
        // negative quotient rounds toward minus infinity when inexact: -q-1 = ~q
        if (neg) begin
          q <= (rem != 32'd0) ? ~q : (~q + 32'd1);
        end
      end
    end
  end

  assign quotient = q;

endmodule

>>> sv/sc_dp.sv
// Datapath: stack memory, entry count, arithmetic unit and result register.
module sc_dp #(
  parameter int STACK_DEPTH = sc_pkg::STACK_DEPTH_DEF,
  parameter int CNT_W = $clog2(STACK_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sc_pkg::cmd_t                 cmd,
  output sc_pkg::stat_t                stat,
  input  logic [sc_pkg::OP_W-1:0]      operation,
  input  logic signed [31:0]           push_value,
  input  logic [sc_pkg::POS_W-1:0]     position,
  output logic signed [31:0]           value,
  output logic [sc_pkg::ST_W-1:0]      status,
  output logic [CNT_W-1:0]             depth_used
);

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = (CNT_W > sc_pkg::POS_W) ? CNT_W : sc_pkg::POS_W;

  logic [sc_pkg::OP_W-1:0]  op_r;
  logic [31:0]              pv_r;
  logic [sc_pkg::POS_W-1:0] pos_r;
  logic [CNT_W-1:0]         n;
  logic [CNT_W-1:0]         n_next;
  logic [31:0]              a_reg;
  logic [31:0]              b_reg;
  logic [31:0]              res_reg;
  logic [31:0]              mem [STACK_DEPTH];
  logic [31:0]              mem_q;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     we;
  logic [PW-1:0]            n_ext;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            top_idx;
  logic [CNT_W-1:0]         n_m1;
  logic [CNT_W-1:0]         n_m2;
  logic [sc_pkg::ST_W-1:0]  code;
  logic [31:0]              result;
  logic [63:0]              prod;
  logic                     is_binary;
  logic                     div_done;
  logic [31:0]              div_q;

  sc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (a_reg),
    .divisor  (b_reg),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    n_ext = PW'(n);
    pos_ext = PW'(pos_r);
    top_idx = n_ext - PW'(1) - pos_ext;
    n_m1 = n - CNT_W'(1);
    n_m2 = n - CNT_W'(2);
    is_binary = (op_r == sc_pkg::OP_ADD) || (op_r == sc_pkg::OP_SUB) ||
                (op_r == sc_pkg::OP_MUL) || (op_r == sc_pkg::OP_DIV);
  end

  // status of the latched operation; divide by zero only counts once b is loaded
  always_comb begin
    code = sc_pkg::ST_OK;
    case (op_r)
      sc_pkg::OP_PUSH: begin
        if (n == CNT_W'(STACK_DEPTH)) code = sc_pkg::ST_FULL;
      end
      sc_pkg::OP_POP: begin
        if (n == CNT_W'(0)) code = sc_pkg::ST_EMPTY;
      end
      sc_pkg::OP_ADD, sc_pkg::OP_SUB, sc_pkg::OP_MUL, sc_pkg::OP_DIV: begin
        if (n < CNT_W'(2)) code = sc_pkg::ST_FEW;
        else if (op_r == sc_pkg::OP_DIV && b_reg == 32'd0) code = sc_pkg::ST_DIVZERO;
      end
      default: begin
        if (pos_ext >= n_ext) code = sc_pkg::ST_RANGE;
      end
    endcase
  end

  always_comb begin
    stat.err_early = (code != sc_pkg::ST_OK) && (code != sc_pkg::ST_DIVZERO);
    stat.is_push = (op_r == sc_pkg::OP_PUSH);
    stat.is_binary = is_binary;
    stat.is_div = (op_r == sc_pkg::OP_DIV);
    stat.b_zero = (b_reg == 32'd0);
    stat.div_done = div_done;
  end

  always_comb begin
    if (cmd.rd_next) begin
      rd_addr = n_m2[ADDR_W-1:0];
    end else if (op_r == sc_pkg::OP_RD_TOP) begin
      rd_addr = top_idx[ADDR_W-1:0];
    end else if (op_r == sc_pkg::OP_RD_BOT) begin
      rd_addr = pos_ext[ADDR_W-1:0];
    end else begin
      rd_addr = n_m1[ADDR_W-1:0];
    end
  end

  always_comb begin
    if (code != sc_pkg::ST_OK) begin
      result = 32'd0;
    end else if (op_r == sc_pkg::OP_PUSH) begin
      result = pv_r;
    end else if (op_r == sc_pkg::OP_DIV) begin
      result = div_q;
    end else if (is_binary) begin
      result = res_reg;
    end else begin
      result = b_reg;
    end
  end

  always_comb begin
    n_next = n;
    we = 1'b0;
    wr_addr = n[ADDR_W-1:0];
    if (cmd.commit && code == sc_pkg::ST_OK) begin
      if (op_r == sc_pkg::OP_PUSH) begin
        n_next = n + CNT_W'(1);
        we = 1'b1;
      end else if (is_binary) begin
        n_next = n_m1;
        we = 1'b1;
        wr_addr = n_m2[ADDR_W-1:0];
      end else if (op_r == sc_pkg::OP_POP) begin
        n_next = n_m1;
      end
    end
  end

  assign prod = a_reg * b_reg;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= result;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else begin
      n <= n_next;
    end
    if (cmd.load) begin
      op_r <= operation;
      pv_r <= push_value;
      pos_r <= position;
    end
    if (cmd.cap_b) b_reg <= mem_q;
    if (cmd.cap_a) a_reg <= mem_q;
    if (cmd.exec) begin
      case (op_r)
        sc_pkg::OP_ADD: res_reg <= a_reg + b_reg;
        sc_pkg::OP_SUB: res_reg <= a_reg - b_reg;
        default:        res_reg <= prod[31:0];
      endcase
    end
    if (cmd.commit) begin
      value <= result;
      status <= code;
      depth_used <= n_next;
    end
  end

endmodule

>>> sv/sc_ctrl.sv
// Controller: sequences operand reads, arithmetic and result commit per item.
module sc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sc_pkg::stat_t stat,
  output sc_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RDA,
    S_CAPA,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // top (or read) address is issued here
        if (stat.err_early || stat.is_push) state_next = S_DONE;
        else state_next = S_RDA;
      end
      S_RDA: begin
        cmd.cap_b = 1'b1;
        cmd.rd_next = 1'b1;
        state_next = stat.is_binary ? S_CAPA : S_DONE;
      end
      S_CAPA: begin
        cmd.cap_a = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_div) begin
          if (stat.b_zero) begin
            state_next = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end
        end else begin
          cmd.exec = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
